// ===== hdl/dtp_pkg.sv =====
// Package for the distance-to-position classifier.
// Field widths, action and status codes, beat structs and scaling constants.
// No dependencies.
package dtp_pkg;

    localparam int DIST_W = 13;
    localparam int WGT_W  = 8;
    localparam int IDX_W  = 4;
    localparam int CNT_W  = 5;

    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_BUILD  = 2'd1;
    localparam logic [1:0] ACT_SAMPLE = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam logic [1:0] ST_FOUND  = 2'd0;
    localparam logic [1:0] ST_NOCAL  = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;
    localparam logic [1:0] ST_BUILT  = 2'd3;

    localparam logic [DIST_W-1:0] SINGLE_HALF_GAP = 13'd50;

    // zone = gap * 30 / 100, done as gap * 3 / 10 with a reciprocal
    localparam int ZONE_PERCENT = 30;
    localparam int PERCENT_BASE = 100;
    localparam int ZONE_NUM     = ZONE_PERCENT / 10;
    localparam int ZONE_DEN     = PERCENT_BASE / 10;
    localparam int RECIP_SHIFT  = 19;
    localparam int RECIP        = ((1 << RECIP_SHIFT) + ZONE_DEN - 1) / ZONE_DEN;
    localparam int RECIP_W      = 16;

    typedef struct packed {
        logic [1:0]        action;
        logic [IDX_W-1:0]  point_index;
        logic [DIST_W-1:0] point_distance;
        logic [WGT_W-1:0]  point_weight;
        logic              point_valid;
        logic [DIST_W-1:0] sample_distance;
        logic              last_sample;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]        status;
        logic [WGT_W-1:0]  weight;
        logic [DIST_W-1:0] median_mm;
        logic [CNT_W-1:0]  kept_samples;
        logic [CNT_W-1:0]  point_count;
        logic              low_confidence;
        logic              non_monotonic;
    } t_out_beat;

endpackage

// ===== hdl/dtp_if.sv =====
// Valid/ready channels of the classifier: command beats in, result beats out.
// Depends on dtp_pkg for the beat structs.
interface dtp_in_if;
    import dtp_pkg::*;
    logic     valid;
    logic     ready;
    t_in_beat data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dtp_out_if;
    import dtp_pkg::*;
    logic      valid;
    logic      ready;
    t_out_beat data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/dtp_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dtp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/dtp_div.sv =====
// Restoring divider, one quotient bit per cycle, for the calibration half-gap.
// Depends on dtp_pkg for the distance width.
module dtp_div #(
    parameter int DEN_W = 5
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [dtp_pkg::DIST_W-1:0] i_num,
    input  logic [DEN_W-1:0]          i_den,
    output logic                      o_done,
    output logic [dtp_pkg::DIST_W-1:0] o_quot
);
    import dtp_pkg::*;

    localparam int CW = $clog2(DIST_W);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [DIST_W-1:0] r_q;
    logic [DEN_W-1:0]  r_rem;

    logic [DEN_W:0] w_shift;
    logic [DEN_W:0] w_diff;
    logic           w_ge;

    assign w_shift = {r_rem, r_q[DIST_W-1]};
    assign w_ge    = w_shift >= {1'b0, i_den};
    assign w_diff  = w_shift - {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_q    <= i_num;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_q   <= {r_q[DIST_W-2:0], w_ge};
                r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_shift[DEN_W-1:0];
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DIST_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

// ===== hdl/distance_to_position_classifier.sv =====
// Distance-to-position classifier top level: command sequencer around the
// table, sorted-point and burst memories. Depends on dtp_pkg, dtp_if, dtp_ram, dtp_div.
//
//  channel  dir  beat        moves
//  i_in     in   t_in_beat   load point, build, distance sample
//  o_out    out  t_out_beat  build report or classification
//
// Loads and non-final samples are taken in S_IDLE, which keeps i_in.ready high.
// A build or a final sample leaves S_IDLE and holds i_in.ready low until its
// result is in the output register; both scan their memories in nested loops
// through the single read port of each memory.
// Reset clears the valid bits and counts; memory contents stay undefined.
// A result waiting on o_out stalls only the next build or final sample.
module distance_to_position_classifier #(
    parameter int TABLE_POINTS = 16,
    parameter int BURST_DEPTH  = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dtp_in_if.sink    i_in,
    dtp_out_if.source o_out
);
    import dtp_pkg::*;

    localparam int TW  = $clog2(TABLE_POINTS);
    localparam int TCW = $clog2(TABLE_POINTS + 1);
    localparam int BW  = (BURST_DEPTH > 1) ? $clog2(BURST_DEPTH) : 1;
    localparam int BCW = $clog2(BURST_DEPTH + 1);
    localparam int XW  = (TCW > BCW) ? TCW : BCW;
    localparam int PW  = DIST_W + WGT_W;

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_BOUT = 11'b00000000010,
        S_BIN  = 11'b00000000100,
        S_BWR  = 11'b00000001000,
        S_BDIV = 11'b00000010000,
        S_BLIM = 11'b00000100000,
        S_CK   = 11'b00001000000,
        S_CMRD = 11'b00010000000,
        S_CMIN = 11'b00100000000,
        S_CB   = 11'b01000000000,
        S_OUT  = 11'b10000000000
    } t_state;

    t_state             r_state;
    logic               r_ph;
    logic [TABLE_POINTS-1:0] r_valid;
    logic [XW-1:0]      r_i, r_j;
    logic [TCW-1:0]     r_n, r_pc;
    logic [TW-1:0]      r_rank;
    logic               r_eq;
    logic [DIST_W-1:0]  r_key_d;
    logic [WGT_W-1:0]   r_key_w;
    logic [DIST_W-1:0]  r_min, r_max, r_half, r_lo, r_med;
    logic [DIST_W:0]    r_hi;
    logic [BCW-1:0]     r_bcnt, r_nb, r_kept, r_less, r_le;
    logic               r_found, r_lowc;
    logic [DIST_W-1:0]  r_prev_d;
    logic [WGT_W-1:0]   r_prev_w, r_wsel;
    t_out_beat          r_res;
    logic               r_ovalid;
    t_out_beat          r_odata;

    logic              w_acc;
    logic [TW+IDX_W-1:0] w_pidx;
    logic              w_pidx_ok;
    logic              w_tab_we;
    logic [TW-1:0]     w_tab_raddr;
    logic [PW-1:0]     w_tab_rdata;
    logic [PW-1:0]     w_srt_rdata;
    logic              w_bur_we;
    logic [BW-1:0]     w_bur_raddr;
    logic [DIST_W-1:0] w_bur_rdata;
    logic              w_div_start;
    logic              w_div_done;
    logic [DIST_W-1:0] w_div_quot;
    logic [DIST_W-1:0] w_td, w_cd;
    logic              w_b_in;
    logic [DIST_W-1:0] w_gap;
    logic [DIST_W+1:0] w_gap3;
    logic [DIST_W+1+RECIP_W:0] w_prod;
    logic [DIST_W-1:0] w_zone;
    logic [DIST_W-1:0] w_bnd;
    logic [DIST_W:0]   w_bsum;
    logic [DIST_W-1:0] w_blo;
    logic              w_inzone;
    logic [BCW-1:0]    w_half_k;

    assign w_acc      = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign w_pidx     = {{TW{1'b0}}, i_in.data.point_index};
    assign w_pidx_ok  = w_pidx < (TW + IDX_W)'(TABLE_POINTS);
    assign w_tab_we   = w_acc && (i_in.data.action == ACT_LOAD) && w_pidx_ok;
    assign w_bur_we   = w_acc && (i_in.data.action == ACT_SAMPLE)
                        && (r_bcnt < BCW'(BURST_DEPTH));
    assign w_tab_raddr = (r_state == S_BIN) ? r_j[TW-1:0] : r_i[TW-1:0];
    assign w_bur_raddr = (r_state == S_CMRD) ? r_i[BW-1:0] : r_j[BW-1:0];
    assign w_td = w_tab_rdata[PW-1:WGT_W];
    assign w_cd = w_srt_rdata[PW-1:WGT_W];
    assign w_b_in = (w_bur_rdata >= r_lo) && ({1'b0, w_bur_rdata} <= r_hi);
    assign w_div_start = (r_state == S_BOUT) && (r_i == XW'(TABLE_POINTS))
                         && (r_n >= TCW'(2));
    assign w_half_k = r_kept >> 1;

    // boundary and its low-confidence zone between the previous and current point
    assign w_gap    = w_cd - r_prev_d;
    assign w_gap3   = (DIST_W + 2)'(w_gap) * (DIST_W + 2)'(ZONE_NUM);
    assign w_prod   = (DIST_W + 2 + RECIP_W)'(w_gap3) * (DIST_W + 2 + RECIP_W)'(RECIP);
    assign w_zone   = DIST_W'(w_prod >> RECIP_SHIFT);
    assign w_bsum   = {1'b0, r_prev_d} + {1'b0, w_cd};
    assign w_bnd    = w_bsum[DIST_W:1];
    assign w_blo    = (w_bnd > w_zone) ? (w_bnd - w_zone) : '0;
    assign w_inzone = (r_med >= w_blo)
                      && ({1'b0, r_med} <= ({1'b0, w_bnd} + {1'b0, w_zone}));

    dtp_ram #(.WIDTH(PW), .DEPTH(TABLE_POINTS)) u_table (
        .i_clk   (i_clk),
        .i_we    (w_tab_we),
        .i_waddr (w_pidx[TW-1:0]),
        .i_wdata ({i_in.data.point_distance, i_in.data.point_weight}),
        .i_raddr (w_tab_raddr),
        .o_rdata (w_tab_rdata)
    );

    dtp_ram #(.WIDTH(PW), .DEPTH(TABLE_POINTS)) u_sorted (
        .i_clk   (i_clk),
        .i_we    (r_state == S_BWR),
        .i_waddr (r_rank),
        .i_wdata ({r_key_d, r_key_w}),
        .i_raddr (r_j[TW-1:0]),
        .o_rdata (w_srt_rdata)
    );

    dtp_ram #(.WIDTH(DIST_W), .DEPTH(BURST_DEPTH)) u_burst (
        .i_clk   (i_clk),
        .i_we    (w_bur_we),
        .i_waddr (r_bcnt[BW-1:0]),
        .i_wdata (i_in.data.sample_distance),
        .i_raddr (w_bur_raddr),
        .o_rdata (w_bur_rdata)
    );

    dtp_div #(.DEN_W(TCW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_max - r_min),
        .i_den   (r_n - 1'b1),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ph     <= 1'b0;
            r_valid  <= '0;
            r_pc     <= '0;
            r_bcnt   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // S_OUT reloads the output register itself
            if (o_out.ready && (r_state != S_OUT)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_tab_we) begin
                        r_valid[w_pidx[TW-1:0]] <= i_in.data.point_valid;
                    end
                    if (w_acc && (i_in.data.action == ACT_BUILD)) begin
                        r_i     <= '0;
                        r_n     <= '0;
                        r_eq    <= 1'b0;
                        r_min   <= '1;
                        r_max   <= '0;
                        r_ph    <= 1'b0;
                        r_state <= S_BOUT;
                    end
                    if (w_acc && (i_in.data.action == ACT_SAMPLE)) begin
                        if (w_bur_we && !i_in.data.last_sample) begin
                            r_bcnt <= r_bcnt + 1'b1;
                        end
                        if (i_in.data.last_sample) begin
                            r_nb   <= w_bur_we ? (r_bcnt + 1'b1) : r_bcnt;
                            r_bcnt <= '0;
                            if (r_pc == '0) begin
                                r_res   <= '{status: ST_NOCAL, default: '0};
                                r_state <= S_OUT;
                            end else begin
                                r_j     <= '0;
                                r_kept  <= '0;
                                r_ph    <= 1'b0;
                                r_state <= S_CK;
                            end
                        end
                    end
                end
                S_BOUT: begin
                    if (r_i == XW'(TABLE_POINTS)) begin
                        r_pc <= r_n;
                        if (r_n >= TCW'(2)) begin
                            r_state <= S_BDIV;
                        end else begin
                            r_half  <= SINGLE_HALF_GAP;
                            r_state <= S_BLIM;
                        end
                    end else if (!r_valid[r_i[TW-1:0]]) begin
                        r_i <= r_i + 1'b1;
                    end else if (!r_ph) begin
                        r_ph <= 1'b1;
                    end else begin
                        r_ph    <= 1'b0;
                        r_key_d <= w_td;
                        r_key_w <= w_tab_rdata[WGT_W-1:0];
                        r_n     <= r_n + 1'b1;
                        if (w_td < r_min) r_min <= w_td;
                        if (w_td > r_max) r_max <= w_td;
                        r_j     <= '0;
                        r_rank  <= '0;
                        r_state <= S_BIN;
                    end
                end
                S_BIN: begin
                    if (r_j == XW'(TABLE_POINTS)) begin
                        r_state <= S_BWR;
                    end else if (!r_valid[r_j[TW-1:0]]) begin
                        r_j <= r_j + 1'b1;
                    end else if (!r_ph) begin
                        r_ph <= 1'b1;
                    end else begin
                        r_ph <= 1'b0;
                        r_j  <= r_j + 1'b1;
                        // stable rank: earlier slots win ties
                        if ((w_td < r_key_d) || ((w_td == r_key_d) && (r_j < r_i))) begin
                            r_rank <= r_rank + 1'b1;
                        end
                        if ((w_td == r_key_d) && (r_j != r_i)) begin
                            r_eq <= 1'b1;
                        end
                    end
                end
                S_BWR: begin
                    r_i     <= r_i + 1'b1;
                    r_state <= S_BOUT;
                end
                S_BDIV: begin
                    if (w_div_done) begin
                        r_half  <= w_div_quot >> 1;
                        r_state <= S_BLIM;
                    end
                end
                S_BLIM: begin
                    r_lo    <= (r_min > r_half) ? (r_min - r_half) : '0;
                    r_hi    <= {1'b0, r_max} + {1'b0, r_half};
                    r_res   <= '{status: ST_BUILT, point_count: CNT_W'(r_n),
                                 non_monotonic: r_eq, default: '0};
                    r_state <= S_OUT;
                end
                S_CK: begin
                    if (r_j == XW'(r_nb)) begin
                        if (r_kept == '0) begin
                            r_res   <= '{status: ST_REJECT, point_count: CNT_W'(r_pc),
                                         default: '0};
                            r_state <= S_OUT;
                        end else begin
                            r_i     <= '0;
                            r_state <= S_CMRD;
                        end
                    end else if (!r_ph) begin
                        r_ph <= 1'b1;
                    end else begin
                        r_ph <= 1'b0;
                        r_j  <= r_j + 1'b1;
                        if (w_b_in) r_kept <= r_kept + 1'b1;
                    end
                end
                S_CMRD: begin
                    if (!r_ph) begin
                        r_ph <= 1'b1;
                    end else begin
                        r_ph <= 1'b0;
                        if (w_b_in) begin
                            r_key_d <= w_bur_rdata;
                            r_j     <= '0;
                            r_less  <= '0;
                            r_le    <= '0;
                            r_state <= S_CMIN;
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end
                end
                S_CMIN: begin
                    if (r_j == XW'(r_nb)) begin
                        // candidate is the median if it covers rank kept/2
                        if ((r_less <= w_half_k) && (w_half_k < r_le)) begin
                            r_med   <= r_key_d;
                            r_j     <= '0;
                            r_found <= 1'b0;
                            r_lowc  <= 1'b0;
                            r_state <= S_CB;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_CMRD;
                        end
                    end else if (!r_ph) begin
                        r_ph <= 1'b1;
                    end else begin
                        r_ph <= 1'b0;
                        r_j  <= r_j + 1'b1;
                        if (w_b_in && (w_bur_rdata < r_key_d)) r_less <= r_less + 1'b1;
                        if (w_b_in && (w_bur_rdata <= r_key_d)) r_le <= r_le + 1'b1;
                    end
                end
                S_CB: begin
                    if (r_j == XW'(r_pc)) begin
                        r_res   <= '{status: ST_FOUND,
                                     weight: r_found ? r_wsel : r_prev_w,
                                     median_mm: r_med,
                                     kept_samples: CNT_W'(r_kept),
                                     point_count: CNT_W'(r_pc),
                                     low_confidence: r_lowc,
                                     non_monotonic: 1'b0};
                        r_state <= S_OUT;
                    end else if (!r_ph) begin
                        r_ph <= 1'b1;
                    end else begin
                        r_ph     <= 1'b0;
                        r_j      <= r_j + 1'b1;
                        r_prev_d <= w_cd;
                        r_prev_w <= w_srt_rdata[WGT_W-1:0];
                        if (r_j != '0) begin
                            if (!r_found && (r_med < w_bnd)) begin
                                r_found <= 1'b1;
                                r_wsel  <= r_prev_w;
                            end
                            if (w_inzone) r_lowc <= 1'b1;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= r_res;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_odata;

`ifndef SYNTH
    a_burst_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bcnt <= BCW'(BURST_DEPTH))
        else $error("burst count beyond buffer depth");
    a_kept_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_CMRD) || (r_state == S_CMIN) || (r_state == S_CB))
        |-> ((r_kept <= r_nb) && (r_kept != '0)))
        else $error("kept count inconsistent with burst");
    a_build_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (i_in.data.action == ACT_BUILD)) |=> (r_state == S_BOUT))
        else $error("build beat did not start the table scan");
    a_median_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMRD) |-> (r_i < XW'(r_nb)))
        else $error("median search ran past the burst");
`endif
endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench of distance_to_position_classifier: table loads,
// builds and distance bursts, checked against an in-bench predictor.
// Depends on dtp_pkg, dtp_if and the classifier RTL.
module tb_top;
    import dtp_pkg::*;

    localparam int NPTS      = 16;
    localparam int NBURST    = 16;
    localparam int TAIL_WAIT = 800;
    localparam int LIMIT     = 5000000;

    logic i_clk;
    logic i_rst_n;
    dtp_in_if  cmd_ch ();
    dtp_out_if res_ch ();

    distance_to_position_classifier #(.TABLE_POINTS(NPTS), .BURST_DEPTH(NBURST)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (cmd_ch.sink),
        .o_out  (res_ch.source)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor state
    logic [DIST_W-1:0] cal_dist [NPTS];
    logic [WGT_W-1:0]  cal_wgt  [NPTS];
    logic              cal_used [NPTS];
    logic [DIST_W-1:0] pos_dist [NPTS];
    logic [WGT_W-1:0]  pos_wgt  [NPTS];
    logic [DIST_W-1:0] edge_mm  [NPTS];
    int unsigned       pos_cnt;
    logic [DIST_W-1:0] burst_mm [NBURST];
    int unsigned       burst_cnt;

    t_out_beat   expected_q[$];
    int unsigned fail_cnt  = 0;
    int unsigned sent_cnt  = 0;
    int unsigned cycle_cnt = 0;
    bit          quiet     = 1'b0;

    function automatic t_out_beat predict_build();
        t_out_beat r;
        int unsigned n;
        int unsigned j;
        logic [DIST_W-1:0] kd;
        logic [WGT_W-1:0]  kw;
        n = 0;
        r = '0;
        for (int i = 0; i < NPTS; i++) begin
            if (cal_used[i]) begin
                pos_dist[n] = cal_dist[i];
                pos_wgt[n]  = cal_wgt[i];
                n++;
            end
        end
        pos_cnt = n;
        r.status = ST_BUILT;
        r.point_count = CNT_W'(n);
        if (n >= 2) begin
            // stable insertion sort on distance
            for (int i = 1; i < n; i++) begin
                kd = pos_dist[i];
                kw = pos_wgt[i];
                j = i;
                while (j > 0 && pos_dist[j-1] > kd) begin
                    pos_dist[j] = pos_dist[j-1];
                    pos_wgt[j]  = pos_wgt[j-1];
                    j--;
                end
                pos_dist[j] = kd;
                pos_wgt[j]  = kw;
            end
            for (int i = 0; i + 1 < n; i++) begin
                edge_mm[i] = DIST_W'((int'(pos_dist[i]) + int'(pos_dist[i+1])) / 2);
                if (pos_dist[i] >= pos_dist[i+1]) r.non_monotonic = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic t_out_beat predict_classify();
        t_out_beat r;
        int unsigned tmp[NBURST];
        int unsigned n, pc, half, lo, hi, kept, first, med, idx, key, j, zone, blo;
        r = '0;
        n = burst_cnt;
        pc = pos_cnt;
        kept = 0;
        first = 0;
        if (pc == 0 || n == 0) begin
            r.status = ST_NOCAL;
            return r;
        end
        for (int i = 0; i < n; i++) tmp[i] = burst_mm[i];
        for (int i = 1; i < n; i++) begin
            key = tmp[i];
            j = i;
            while (j > 0 && tmp[j-1] > key) begin
                tmp[j] = tmp[j-1];
                j--;
            end
            tmp[j] = key;
        end
        if (pc >= 2) half = ((pos_dist[pc-1] - pos_dist[0]) / (pc - 1)) / 2;
        else half = SINGLE_HALF_GAP;
        lo = (pos_dist[0] > half) ? pos_dist[0] - half : 0;
        hi = pos_dist[pc-1] + half;
        for (int i = 0; i < n; i++) begin
            if (tmp[i] >= lo && tmp[i] <= hi) begin
                if (kept == 0) first = i;
                kept++;
            end
        end
        r.point_count = CNT_W'(pc);
        if (kept == 0) begin
            r.status = ST_REJECT;
            return r;
        end
        med = tmp[first + kept / 2];
        idx = pc - 1;
        for (int i = 0; i + 1 < pc; i++) begin
            if (med < edge_mm[i]) begin
                idx = i;
                break;
            end
        end
        for (int i = 0; i + 1 < pc; i++) begin
            zone = (pos_dist[i+1] - pos_dist[i]) * ZONE_PERCENT / PERCENT_BASE;
            blo = (edge_mm[i] > zone) ? edge_mm[i] - zone : 0;
            if (med >= blo && med <= edge_mm[i] + zone) begin
                r.low_confidence = 1'b1;
                break;
            end
        end
        r.status = ST_FOUND;
        r.weight = pos_wgt[idx];
        r.median_mm = DIST_W'(med);
        r.kept_samples = CNT_W'(kept);
        return r;
    endfunction

    task automatic apply_to_predictor(input t_in_beat b);
        if (b.action == ACT_LOAD) begin
            cal_dist[b.point_index] = b.point_distance;
            cal_wgt[b.point_index]  = b.point_weight;
            cal_used[b.point_index] = b.point_valid;
        end else if (b.action == ACT_BUILD) begin
            expected_q.push_back(predict_build());
        end else if (b.action == ACT_SAMPLE) begin
            if (burst_cnt < NBURST) begin
                burst_mm[burst_cnt] = b.sample_distance;
                burst_cnt++;
            end
            if (b.last_sample) begin
                expected_q.push_back(predict_classify());
                burst_cnt = 0;
            end
        end
    endtask

    // random filler in every field, then the fields that matter
    function automatic t_in_beat noise_beat(input logic [1:0] act);
        t_in_beat b;
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        b = raw[$bits(t_in_beat)-1:0];
        b.action = act;
        return b;
    endfunction

    task automatic send_beat(input t_in_beat b);
        int unsigned gap;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            cmd_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= b;
        do @(posedge i_clk); while (!(cmd_ch.valid && cmd_ch.ready));
        apply_to_predictor(b);
        sent_cnt++;
    endtask

    task automatic load_point(input int idx, input int d, input int w, input bit v);
        t_in_beat b;
        b = noise_beat(ACT_LOAD);
        b.point_index = IDX_W'(idx);
        b.point_distance = DIST_W'(d);
        b.point_weight = WGT_W'(w);
        b.point_valid = v;
        send_beat(b);
    endtask

    task automatic sample(input int d, input bit last);
        t_in_beat b;
        b = noise_beat(ACT_SAMPLE);
        b.sample_distance = DIST_W'(d);
        b.last_sample = last;
        send_beat(b);
    endtask

    task automatic build();
        send_beat(noise_beat(ACT_BUILD));
    endtask

    task automatic test_empty_table();
        sample(1000, 1'b1);
        build();
        sample(0, 1'b1);
        send_beat(noise_beat(ACT_UNUSED));
    endtask

    task automatic test_single_point();
        load_point(15, 8191, 255, 1'b1);
        build();
        sample(8141, 1'b0);
        sample(8191, 1'b1);
        load_point(15, 30, 7, 1'b1);
        build();
        sample(0, 1'b1);
    endtask

    task automatic test_equal_points();
        load_point(0, 500, 10, 1'b1);
        load_point(3, 500, 20, 1'b1);
        load_point(7, 200, 30, 1'b1);
        load_point(15, 0, 0, 1'b0);
        build();
        sample(350, 1'b0);
        sample(8191, 1'b1);
    endtask

    task automatic test_overflow_and_reject();
        for (int i = 0; i < NBURST + 3; i++) sample(300 + 10 * i, i == NBURST + 2);
        sample(8191, 1'b0);
        sample(8000, 1'b1);
    endtask

    task automatic test_random_sequences(input int unsigned stop_at);
        int unsigned burst_len;
        int d;
        while (sent_cnt < stop_at) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    repeat ($urandom_range(1, 6)) begin
                        if ($urandom_range(0, 4) == 0) d = $urandom_range(0, 8191);
                        else d = $urandom_range(0, 2500);
                        load_point($urandom_range(0, 15), d, $urandom_range(0, 255),
                                   $urandom_range(0, 4) != 0);
                    end
                end
                3: build();
                4: send_beat(noise_beat(ACT_UNUSED));
                default: begin
                    burst_len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 22)
                                                             : $urandom_range(1, 9);
                    for (int i = 0; i < burst_len; i++) begin
                        if (pos_cnt == 0 || $urandom_range(0, 5) == 0) begin
                            d = $urandom_range(0, 8191);
                        end else begin
                            d = int'(pos_dist[$urandom_range(0, pos_cnt - 1)])
                                + $urandom_range(0, 400) - 200;
                            if (d < 0) d = 0;
                            if (d > 8191) d = 8191;
                        end
                        sample(d, i == burst_len - 1);
                    end
                end
            endcase
        end
    endtask

    // result side: stall in random bursts
    int unsigned stall_left = 0;
    always @(negedge i_clk) begin
        if (quiet) begin
            res_ch.ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            res_ch.ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 12);
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_out_beat exp_r;
        t_out_beat got;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = res_ch.data;
            if (expected_q.size() == 0) begin
                $display("%0t unexpected result %p", $time, got);
                fail_cnt++;
            end else begin
                exp_r = expected_q.pop_front();
                if (got.status !== exp_r.status || got.weight !== exp_r.weight ||
                    got.median_mm !== exp_r.median_mm ||
                    got.kept_samples !== exp_r.kept_samples ||
                    got.point_count !== exp_r.point_count ||
                    got.low_confidence !== exp_r.low_confidence ||
                    got.non_monotonic !== exp_r.non_monotonic) begin
                    $display("%0t mismatch expected %p actual %p", $time, exp_r, got);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        cmd_ch.valid = 1'b0;
        cmd_ch.data  = '0;
        res_ch.ready = 1'b0;
        i_rst_n      = 1'b0;
        for (int i = 0; i < NPTS; i++) cal_used[i] = 1'b0;
        pos_cnt = 0;
        burst_cnt = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_single_point();
        test_equal_points();
        test_overflow_and_reject();
        test_random_sequences(sent_cnt + 650);
        quiet = 1'b1;
        test_random_sequences(sent_cnt + 150);
        @(negedge i_clk);
        cmd_ch.valid <= 1'b0;

        // drain, then let any trailing work settle
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (fail_cnt == 0 && expected_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
